// File: rtl/core/cfos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfos_pkg - shared types and constants of the curl stencil
// Widths, register codes, reset values and the record passed from the
// stencil front end to the scaling back end.
// ----------------------------------------------------------------------------
package cfos_pkg;

    // Grid geometry
    localparam int MAX_COLS    = 1024;
    localparam int GHOST_WIDTH = 2;
    localparam int LINES       = 2 * GHOST_WIDTH;
    localparam int SLOT_W      = $clog2(LINES);

    // Field and register widths
    localparam int SAMPLE_W  = 32;
    localparam int COLS_W    = 10;
    localparam int ROWS_W    = 16;
    localparam int SCALE_W   = 32;
    localparam int ROW_CNT_W = 17;

    // Difference arithmetic: 18 * 2^31 needs 36 magnitude bits plus a sign
    localparam int DIFF_W = 37;
    localparam int MAG_W  = 36;
    localparam int FRAC_W = 16;

    // Decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERIOR_COLS = 2'd0,
        CFG_INTERIOR_ROWS = 2'd1,
        CFG_SCALE_X       = 2'd2,
        CFG_SCALE_Y       = 2'd3
    } t_cfg_reg;

    localparam logic [COLS_W-1:0]  COLS_RST  = 10'd16;
    localparam logic [ROWS_W-1:0]  ROWS_RST  = 16'd16;
    localparam logic [SCALE_W-1:0] SCALE_RST = 32'h0001_0000;

    // Line store read taps, one per line slot
    typedef logic [LINES-1:0][SAMPLE_W-1:0] t_line_taps;

    // Differences of one interior point, front to back
    typedef struct packed {
        logic signed [DIFF_W-1:0] hor;
        logic signed [DIFF_W-1:0] vert;
        logic                     last;
    } t_diff_rec;

endpackage
`default_nettype wire

// File: rtl/core/curl_fourth_order_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// curl_fourth_order_stencil - streamed fourth-order curl of a potential grid
// Takes a ghost-bordered potential grid in raster order and gives the two
// scaled, saturated curl components for every interior point.
//
//   Channel   Direction  Handshake                   Payload
//   -------   ---------  --------------------------  --------------------------
//   input     in         i_in_valid / o_in_ready     i_potential_sample
//   output    out        o_out_valid / i_out_ready   o_field_b1, o_field_b2,
//                                                    o_last_point
//   config    in         i_cfg_we (write only)       i_cfg_index, i_cfg_data
//
// One sample per cycle while o_in_ready is high; the sample that completes a
// point passes the line store read, the queue and the three-stage scaling pipe
// before its result appears.
// Reset is synchronous, active low; it clears counters, queue and pipe valids
// and loads the register defaults. The line store is not cleared.
// A stall at the output fills the back end and the four-entry queue, then
// drops o_in_ready; it rises again right after the edge at which the back end
// next takes a record from the queue.
// ----------------------------------------------------------------------------
module curl_fourth_order_stencil #(
    parameter int MAX_COLS = cfos_pkg::MAX_COLS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [cfos_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [cfos_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic                                   i_in_valid,
    output      logic                                   o_in_ready,
    input  wire logic signed [cfos_pkg::SAMPLE_W-1:0]   i_potential_sample,
    output      logic                                   o_out_valid,
    input  wire logic                                   i_out_ready,
    output      logic signed [cfos_pkg::SAMPLE_W-1:0]   o_field_b1,
    output      logic signed [cfos_pkg::SAMPLE_W-1:0]   o_field_b2,
    output      logic                                   o_last_point
);

    logic [cfos_pkg::COLS_W-1:0]  r_interior_cols;
    logic [cfos_pkg::ROWS_W-1:0]  r_interior_rows;
    logic [cfos_pkg::SCALE_W-1:0] r_scale_x, r_scale_y;

    logic                         push, pop, q_valid;
    cfos_pkg::t_diff_rec          push_rec, q_rec;
    logic [cfos_pkg::Q_CNT_W-1:0] q_count;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interior_cols <= cfos_pkg::COLS_RST;
            r_interior_rows <= cfos_pkg::ROWS_RST;
            r_scale_x       <= cfos_pkg::SCALE_RST;
            r_scale_y       <= cfos_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            case (cfos_pkg::t_cfg_reg'(i_cfg_index))
                cfos_pkg::CFG_INTERIOR_COLS: begin
                    r_interior_cols <= i_cfg_data[cfos_pkg::COLS_W-1:0];
                end
                cfos_pkg::CFG_INTERIOR_ROWS: begin
                    r_interior_rows <= i_cfg_data[cfos_pkg::ROWS_W-1:0];
                end
                cfos_pkg::CFG_SCALE_X: begin
                    r_scale_x <= i_cfg_data[cfos_pkg::SCALE_W-1:0];
                end
                cfos_pkg::CFG_SCALE_Y: begin
                    r_scale_y <= i_cfg_data[cfos_pkg::SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cfos_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_interior_cols    (r_interior_cols),
        .i_interior_rows    (r_interior_rows),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_potential_sample (i_potential_sample),
        .i_q_count          (q_count),
        .o_push             (push),
        .o_rec              (push_rec)
    );

    cfos_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .o_count (q_count)
    );

    cfos_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scale_x    (r_scale_x),
        .i_scale_y    (r_scale_y),
        .i_valid      (q_valid),
        .i_rec        (q_rec),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_field_b1   (o_field_b1),
        .o_field_b2   (o_field_b2),
        .o_last_point (o_last_point)
    );

endmodule
`default_nettype wire

// File: rtl/core/cfos_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfos_line_store - four banks of past grid lines
// Each bank holds one line slot. All banks are read at the same column with
// registered data; the bank of the current slot takes the new sample
// (read-first at the shared address).
// ----------------------------------------------------------------------------
module cfos_line_store #(
    parameter int MAX_COLS = cfos_pkg::MAX_COLS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [$clog2(MAX_COLS)-1:0]         i_addr,
    input  wire logic [cfos_pkg::SLOT_W-1:0]         i_slot,
    input  wire logic [cfos_pkg::SAMPLE_W-1:0]       i_wdata,
    output      cfos_pkg::t_line_taps                o_taps
);

    for (genvar k = 0; k < cfos_pkg::LINES; k++) begin : g_bank
        logic [cfos_pkg::SAMPLE_W-1:0] r_mem [MAX_COLS];
        logic [cfos_pkg::SAMPLE_W-1:0] r_rd;

        // Read the old entry, then overwrite it in the active slot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rd <= r_mem[i_addr];
                if (i_slot == cfos_pkg::SLOT_W'(k)) begin
                    r_mem[i_addr] <= i_wdata;
                end
            end
        end

        assign o_taps[k] = r_rd;
    end

endmodule
`default_nettype wire

// File: rtl/core/cfos_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfos_front - raster tracking and stencil differences
// Accepts one sample a cycle while o_in_ready is high, tracks row and column,
// classifies interior points and forms the horizontal and vertical
// fourth-order differences. Never stalls internally: it admits a sample only
// when the queue has room for everything already in flight.
// ----------------------------------------------------------------------------
module cfos_front #(
    parameter int MAX_COLS = cfos_pkg::MAX_COLS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [cfos_pkg::COLS_W-1:0]          i_interior_cols,
    input  wire logic [cfos_pkg::ROWS_W-1:0]          i_interior_rows,
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_ready,
    input  wire logic signed [cfos_pkg::SAMPLE_W-1:0] i_potential_sample,
    input  wire logic [cfos_pkg::Q_CNT_W-1:0]         i_q_count,
    output      logic                                 o_push,
    output      cfos_pkg::t_diff_rec                  o_rec
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int WW   = $clog2(MAX_COLS + 1);
    localparam int XW   = ((WW > cfos_pkg::COLS_W) ? WW : cfos_pkg::COLS_W) + 1;
    localparam int RW   = cfos_pkg::ROW_CNT_W;
    localparam int DW   = cfos_pkg::DIFF_W;
    localparam int SW   = cfos_pkg::SLOT_W;
    localparam int BRD  = 2 * cfos_pkg::GHOST_WIDTH;
    localparam int Q_CNT_W_P = cfos_pkg::Q_CNT_W + 1;
    localparam logic [XW-1:0] COLS_MAX = XW'(MAX_COLS - BRD);
    localparam logic [XW-1:0] COL_BRD  = XW'(BRD);
    localparam logic [RW-1:0] ROW_BRD  = RW'(BRD);

    // Raster counters
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // Stage A: request in flight to the line store
    logic                          r_a_vld;
    logic [cfos_pkg::SAMPLE_W-1:0] r_a_x;
    logic [SW-1:0]                 r_a_slot;
    logic                          r_a_emit;
    logic                          r_a_last;

    // Centre window (latest four of the row two back) and vertical delay
    logic [cfos_pkg::SAMPLE_W-1:0] r_win [4];
    logic signed [DW-1:0]          r_vd0, r_vd1;

    logic [XW-1:0]        cols_x, cols_eff, w_eff, c_x, c_inc;
    logic [RW-1:0]        rows_x, rows_eff, h_eff, r_inc;
    logic                 emit, last, accept;
    logic [Q_CNT_W_P-1:0] occ;

    cfos_pkg::t_line_taps            taps;
    logic [SW-1:0]                   s_p3, s_p2, s_p1;
    logic signed [DW-1:0]            p4, p3, p1, pa, w0, w1, w3, p2x, vert, hor;
    logic [cfos_pkg::SAMPLE_W-1:0]   p2;

    // Effective grid bounds and point classification
    always_comb begin
        cols_x = XW'(i_interior_cols);
        if (cols_x == '0) begin
            cols_eff = XW'(1);
        end else if (cols_x > COLS_MAX) begin
            cols_eff = COLS_MAX;
        end else begin
            cols_eff = cols_x;
        end
        w_eff = cols_eff + COL_BRD;
        rows_x   = RW'(i_interior_rows);
        rows_eff = (rows_x == '0) ? RW'(1) : rows_x;
        h_eff    = rows_eff + ROW_BRD;
        c_x   = XW'(r_col);
        c_inc = c_x + XW'(1);
        r_inc = r_row + RW'(1);
        emit  = (r_row >= ROW_BRD) && (c_x >= COL_BRD) && (r_row < h_eff) && (c_x < w_eff);
        last  = (r_row == h_eff - RW'(1)) && (c_x == w_eff - XW'(1));
    end

    // Admit only what the queue can absorb
    always_comb begin
        occ        = Q_CNT_W_P'(i_q_count) + Q_CNT_W_P'(r_a_vld);
        o_in_ready = occ < Q_CNT_W_P'(cfos_pkg::Q_DEPTH);
        accept     = i_in_valid && o_in_ready;
    end

    // Advance column, wrap row and grid
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (c_inc >= w_eff) begin
            n_col = '0;
            n_row = (r_inc >= h_eff) ? '0 : r_inc;
        end else begin
            n_col = CW'(c_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // Hold the sample and its class while the line store reads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_x    <= i_potential_sample;
            r_a_slot <= r_row[SW-1:0];
            r_a_emit <= emit;
            r_a_last <= last;
        end
    end

    cfos_line_store #(
        .MAX_COLS (MAX_COLS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (r_col),
        .i_slot  (r_row[SW-1:0]),
        .i_wdata (i_potential_sample),
        .o_taps  (taps)
    );

    // Stencil differences from the line taps and the centre window
    always_comb begin
        s_p3 = r_a_slot + SW'(1);
        s_p2 = r_a_slot + SW'(2);
        s_p1 = r_a_slot + SW'(3);
        p4   = DW'($signed(taps[r_a_slot]));
        p3   = DW'($signed(taps[s_p3]));
        p2   = taps[s_p2];
        p1   = DW'($signed(taps[s_p1]));
        pa   = DW'($signed(r_a_x));
        vert = p4 - (p3 <<< 3) + (p1 <<< 3) - pa;
        w0   = DW'($signed(r_win[0]));
        w1   = DW'($signed(r_win[1]));
        w3   = DW'($signed(r_win[3]));
        p2x  = DW'($signed(p2));
        hor  = w0 - (w1 <<< 3) + (w3 <<< 3) - p2x;
    end

    // Shift the window and the vertical delay once per sample
    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_win[3];
            r_win[3] <= p2;
            r_vd0    <= vert;
            r_vd1    <= r_vd0;
        end
    end

    assign o_push     = r_a_vld && r_a_emit;
    assign o_rec.hor  = hor;
    assign o_rec.vert = r_vd1;
    assign o_rec.last = r_a_last;

endmodule
`default_nettype wire

// File: rtl/core/cfos_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfos_queue - short FIFO between stencil front end and scaling back end
// Holds difference records of interior points; reports its fill level so the
// front end can admit requests without a combinational path from the back.
// ----------------------------------------------------------------------------
module cfos_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire cfos_pkg::t_diff_rec           i_rec,
    input  wire logic                          i_pop,
    output      logic                          o_valid,
    output      cfos_pkg::t_diff_rec           o_rec,
    output      logic [cfos_pkg::Q_CNT_W-1:0]  o_count
);

    localparam int PW = $clog2(cfos_pkg::Q_DEPTH);
    localparam int CW = cfos_pkg::Q_CNT_W;

    cfos_pkg::t_diff_rec r_mem [cfos_pkg::Q_DEPTH];
    logic [PW-1:0]       r_head, r_tail;
    logic [CW-1:0]       r_count;

    // Wrap a pointer at the queue depth
    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        ptr_next = (p == PW'(cfos_pkg::Q_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_rec;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= ptr_next(r_tail);
            end
            if (i_pop) begin
                r_head <= ptr_next(r_head);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_valid = r_count != '0;
    assign o_rec   = r_mem[r_head];
    assign o_count = r_count;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(cfos_pkg::Q_DEPTH))
        else $error("queue fill level beyond depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count < CW'(cfos_pkg::Q_DEPTH))
        else $error("push into a full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from an empty queue");

    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + CW'(1))
        else $error("fill level missed a push");

endmodule
`default_nettype wire

// File: rtl/core/cfos_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfos_back - scaling, rounding and saturation of the differences
// Three stages: magnitude and sign, split Q16.16 products, round to nearest
// (ties away from zero) and saturate into the output register.
// ----------------------------------------------------------------------------
module cfos_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [cfos_pkg::SCALE_W-1:0]          i_scale_x,
    input  wire logic [cfos_pkg::SCALE_W-1:0]          i_scale_y,
    input  wire logic                                  i_valid,
    input  wire cfos_pkg::t_diff_rec                   i_rec,
    output      logic                                  o_pop,
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    output      logic signed [cfos_pkg::SAMPLE_W-1:0]  o_field_b1,
    output      logic signed [cfos_pkg::SAMPLE_W-1:0]  o_field_b2,
    output      logic                                  o_last_point
);

    localparam int MW  = cfos_pkg::MAG_W;
    localparam int FW  = cfos_pkg::FRAC_W;
    localparam int HW  = MW - FW;
    localparam int SCW = cfos_pkg::SCALE_W;
    localparam int HPW = HW + SCW;
    localparam int LPW = FW + SCW;
    localparam int RGW = HPW + 1;
    localparam int OW  = cfos_pkg::SAMPLE_W;
    localparam logic [LPW:0]  ROUND_HALF = (LPW + 1)'(1) << (FW - 1);
    localparam logic [RGW-1:0] POS_LIM   = RGW'({1'b0, {(OW-1){1'b1}}});
    localparam logic [RGW-1:0] NEG_LIM   = RGW'({1'b1, {(OW-1){1'b0}}});

    // Stage 1: magnitudes and result signs
    logic          r_s1_vld, r_s1_neg1, r_s1_neg2, r_s1_last;
    logic [MW-1:0] r_s1_m1, r_s1_m2;
    // Stage 2: partial products
    logic           r_s2_vld, r_s2_neg1, r_s2_neg2, r_s2_last;
    logic [HPW-1:0] r_s2_h1, r_s2_h2;
    logic [LPW-1:0] r_s2_l1, r_s2_l2;
    // Output register
    logic          r_o_vld, r_o_last;
    logic [OW-1:0] r_o_b1, r_o_b2;

    logic rdy_o, rdy2, rdy1;
    logic signed [cfos_pkg::DIFF_W-1:0] abs_h, abs_v;

    // Combine partial products, round, apply sign and saturate
    function automatic logic [OW-1:0] round_sat(input logic [HPW-1:0] h,
                                                input logic [LPW-1:0] l,
                                                input logic neg);
        logic [LPW:0]   lr;
        logic [RGW-1:0] mag;
        logic [OW-1:0]  cl;
        lr  = (LPW + 1)'(l) + ROUND_HALF;
        mag = RGW'(h) + RGW'(lr >> FW);
        cl  = (mag > NEG_LIM) ? NEG_LIM[OW-1:0] : mag[OW-1:0];
        if (mag == '0) begin
            round_sat = '0;
        end else if (!neg) begin
            round_sat = (mag > POS_LIM) ? POS_LIM[OW-1:0] : mag[OW-1:0];
        end else begin
            round_sat = OW'(0) - cl;
        end
    endfunction

    // Per-stage advance
    always_comb begin
        rdy_o = !r_o_vld || i_out_ready;
        rdy2  = !r_s2_vld || rdy_o;
        rdy1  = !r_s1_vld || rdy2;
        o_pop = i_valid && rdy1;
        abs_h = i_rec.hor[cfos_pkg::DIFF_W-1] ? -i_rec.hor : i_rec.hor;
        abs_v = i_rec.vert[cfos_pkg::DIFF_W-1] ? -i_rec.vert : i_rec.vert;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_vld <= i_valid;
            end
            if (rdy2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (rdy_o) begin
                r_o_vld <= r_s2_vld;
            end
        end
    end

    // Stage 1: take the magnitudes; B2 carries an extra negation
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_m1   <= abs_h[MW-1:0];
            r_s1_m2   <= abs_v[MW-1:0];
            r_s1_neg1 <= i_rec.hor[cfos_pkg::DIFF_W-1];
            r_s1_neg2 <= !i_rec.vert[cfos_pkg::DIFF_W-1];
            r_s1_last <= i_rec.last;
        end
    end

    // Stage 2: split each magnitude at the binary point and multiply
    always_ff @(posedge i_clk) begin
        if (r_s1_vld && rdy2) begin
            r_s2_h1   <= HPW'(r_s1_m1[MW-1:FW]) * HPW'(i_scale_y);
            r_s2_l1   <= LPW'(r_s1_m1[FW-1:0]) * LPW'(i_scale_y);
            r_s2_h2   <= HPW'(r_s1_m2[MW-1:FW]) * HPW'(i_scale_x);
            r_s2_l2   <= LPW'(r_s1_m2[FW-1:0]) * LPW'(i_scale_x);
            r_s2_neg1 <= r_s1_neg1;
            r_s2_neg2 <= r_s1_neg2;
            r_s2_last <= r_s1_last;
        end
    end

    // Stage 3: round and saturate into the output register
    always_ff @(posedge i_clk) begin
        if (r_s2_vld && rdy_o) begin
            r_o_b1   <= round_sat(r_s2_h1, r_s2_l1, r_s2_neg1);
            r_o_b2   <= round_sat(r_s2_h2, r_s2_l2, r_s2_neg2);
            r_o_last <= r_s2_last;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_field_b1   = $signed(r_o_b1);
    assign o_field_b2   = $signed(r_o_b2);
    assign o_last_point = r_o_last;

endmodule
`default_nettype wire
